// ===== src/vba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vba_pkg
// types and constants shared by the segment allocator
// ----------------------------------------------------------------------------
package vba_pkg;

  localparam int MaxSegments = 64;
  localparam int AddrBits    = 20;
  localparam int IdBits      = 16;
  localparam int IdxBits     = $clog2(MaxSegments);
  localparam int CntBits     = $clog2(MaxSegments + 1);
  localparam int SizeBits    = AddrBits + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_REINIT = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NO_ID   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_RSVD  = 2'd3
  } policy_e;

  localparam logic [0:0] CfgPolicy = 1'b0;
  localparam logic [0:0] CfgMemSize = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [20:0] request_size;
    logic [15:0] release_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_id;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_ALLOC_CHK,
    S_SHIFT_UP,
    S_SPLIT,
    S_FREE_SCAN,
    S_FREE_LO,
    S_FREE_HI,
    S_SHIFT_DN,
    S_SCAN_DN_W,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== src/variable_block_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// variable_block_allocator_unit
// address-ordered segment table with first, best or worst fit and coalescing
// ----------------------------------------------------------------------------
// steps: allocate scans segments, shifts entries up on a split, then writes;
//   free scans for the id, merges neighbours, then shifts entries down;
//   reinit and early rejects go straight to the result
// throughput: one item at a time, busy high until the result beat
// one memory port per cycle sets the pace; the result strobe cannot be stalled
// reset: asynchronous, one free segment of 1024 bytes, id counter 1
module variable_block_allocator_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire vba_pkg::req_t       req_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [20:0]         cfg_data_i,
  output logic                     done_o,
  output vba_pkg::rsp_t            rsp_o
);
  import vba_pkg::*;

  localparam int EntBits = AddrBits + SizeBits + IdBits;

  // segment table: start, size, owner in one memory; free bits in flops
  logic [EntBits-1:0]   mem_q [MaxSegments];
  logic [MaxSegments-1:0] free_q, free_d;
  logic [IdxBits-1:0]   rd_addr, wr_addr;
  logic                 wr_en;
  logic [EntBits-1:0]   wr_data, rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  state_e               state_q, state_d;
  logic [1:0]           policy_q;
  logic [20:0]          memsz_q;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [IdBits-1:0]    idc_q, idc_d;
  req_t                 req_q, req_d;
  logic [CntBits-1:0]   i_q, i_d;
  logic [IdxBits-1:0]   pick_q, pick_d;
  logic                 found_q, found_d;
  logic [SizeBits-1:0]  psize_q, psize_d;
  logic [AddrBits-1:0]  pstart_q, pstart_d;
  logic [SizeBits-1:0]  acc_q, acc_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 done_q, done_d;

  logic [AddrBits-1:0]  r_start;
  logic [SizeBits-1:0]  r_size;
  logic [IdBits-1:0]    r_owner;
  logic [SizeBits-1:0]  init_sz;
  logic [IdxBits-1:0]   i_idx;

  assign r_start = rd_q[EntBits-1 -: AddrBits];
  assign r_size  = rd_q[IdBits +: SizeBits];
  assign r_owner = rd_q[IdBits-1:0];
  assign i_idx   = i_q[IdxBits-1:0];
  assign init_sz = (memsz_q > SizeBits'(1 << AddrBits)) ? SizeBits'(1 << AddrBits)
                                                        : SizeBits'(memsz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      policy_q <= POL_FIRST;
      memsz_q  <= 21'd1024;
      cnt_q    <= CntBits'(1);
      idc_q    <= IdBits'(1);
      free_q   <= MaxSegments'(1);
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idc_q   <= idc_d;
      free_q  <= free_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPolicy) policy_q <= cfg_data_i[1:0];
        else                        memsz_q  <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    i_q      <= i_d;
    pick_q   <= pick_d;
    found_q  <= found_d;
    psize_q  <= psize_d;
    pstart_q <= pstart_d;
    acc_q    <= acc_d;
    rsp_q    <= rsp_d;
  end

  // reset image of entry 0 is written on the first reinit or the first write to entry 0;
  // until then entry 0 reads through a flag
  logic init_q, init_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else         init_q <= init_d;
  end

  logic [AddrBits-1:0] e_start;
  logic [SizeBits-1:0] e_size;
  logic [IdBits-1:0]   e_owner;
  logic [IdxBits-1:0]  rd_prev_q;
  always_ff @(posedge clk_i) rd_prev_q <= rd_addr;
  always_comb begin
    e_start = r_start;
    e_size  = r_size;
    e_owner = r_owner;
    if (init_q && rd_prev_q == '0) begin
      e_start = '0;
      e_size  = SizeBits'(1024);
      e_owner = '0;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idc_d    = idc_q;
    free_d   = free_q;
    req_d    = req_q;
    i_d      = i_q;
    pick_d   = pick_q;
    found_d  = found_q;
    psize_d  = psize_q;
    pstart_d = pstart_q;
    acc_d    = acc_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    init_d   = init_q;
    rd_addr  = i_idx;
    wr_en    = 1'b0;
    wr_addr  = i_idx;
    wr_data  = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          rsp_d   = '{status: ST_OK, alloc_id: '0};
          i_d     = '0;
          found_d = 1'b0;
          rd_addr = '0;
          case (action_e'(req_i.action))
            ACT_ALLOC: begin
              if (req_i.request_size == '0 || idc_q == '0) begin
                rsp_d.status = ST_NO_FIT;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_FREE:   state_d = S_FREE_SCAN;
            ACT_REINIT: begin
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = {AddrBits'(0), init_sz, IdBits'(0)};
              init_d  = 1'b0;
              free_d  = MaxSegments'(1);
              cnt_d   = CntBits'(1);
              idc_d   = IdBits'(1);
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // entry i is being read
      S_SCAN: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (free_q[i_idx] && e_size >= req_q.request_size) begin
          if (!found_q ||
              (policy_q == POL_BEST  && e_size < psize_q) ||
              (policy_q == POL_WORST && e_size > psize_q)) begin
            found_d  = 1'b1;
            pick_d   = i_idx;
            psize_d  = e_size;
            pstart_d = e_start;
          end
        end
        if ((free_q[i_idx] && e_size >= req_q.request_size &&
             policy_q != POL_BEST && policy_q != POL_WORST) ||
            i_q + CntBits'(1) >= cnt_q) begin
          state_d = S_ALLOC_CHK;
        end else begin
          i_d     = i_q + CntBits'(1);
          rd_addr = IdxBits'(i_q + CntBits'(1));
          state_d = S_SCAN;
        end
      end
      S_ALLOC_CHK: begin
        if (!found_q) begin
          rsp_d.status = ST_NO_FIT;
          state_d      = S_DONE;
        end else if (psize_q > req_q.request_size) begin
          if (cnt_q >= CntBits'(MaxSegments)) begin
            rsp_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            // shift entries above pick up by one, top first
            i_d     = cnt_q;
            rd_addr = IdxBits'(cnt_q - CntBits'(1));
            state_d = (cnt_q - CntBits'(1) > CntBits'(pick_q)) ? S_SHIFT_UP : S_SPLIT;
          end
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SHIFT_UP: begin
        // rd_q holds entry i-1
        wr_en   = 1'b1;
        wr_addr = i_idx;
        wr_data = {e_start, e_size, e_owner};
        free_d[i_idx] = free_q[IdxBits'(i_q - CntBits'(1))];
        i_d     = i_q - CntBits'(1);
        rd_addr = IdxBits'(i_q - CntBits'(2));
        if (i_q - CntBits'(2) <= CntBits'(pick_q)) state_d = S_SPLIT;
      end
      S_SPLIT: begin
        wr_en = 1'b1;
        if (psize_q > req_q.request_size) begin
          // free remainder goes to pick+1 first, then pick itself
          wr_addr = IdxBits'(pick_q + IdxBits'(1));
          wr_data = {AddrBits'(pstart_q + AddrBits'(req_q.request_size)),
                     SizeBits'(psize_q - req_q.request_size), IdBits'(0)};
          free_d[IdxBits'(pick_q + IdxBits'(1))] = 1'b1;
          cnt_d   = cnt_q + CntBits'(1);
          psize_d = req_q.request_size;
        end else begin
          wr_addr = pick_q;
          wr_data = {pstart_q, psize_q, idc_q};
          if (pick_q == '0) init_d = 1'b0;
          free_d[pick_q] = 1'b0;
          rsp_d.alloc_id = idc_q;
          idc_d   = idc_q + IdBits'(1);
          state_d = S_DONE;
        end
      end
      S_FREE_SCAN: state_d = S_FREE_LO;
      S_FREE_LO: begin
        // compare entry i
        if (!free_q[i_idx] && e_owner == req_q.release_id) begin
          pick_d   = i_idx;
          psize_d  = e_size;
          pstart_d = e_start;
          free_d[i_idx] = 1'b1;
          // read lower neighbour
          rd_addr  = IdxBits'(i_q - CntBits'(1));
          state_d  = S_FREE_HI;
          found_d  = 1'b0;
        end else if (i_q + CntBits'(1) >= cnt_q) begin
          rsp_d.status = ST_NO_ID;
          state_d      = S_DONE;
        end else begin
          i_d     = i_q + CntBits'(1);
          rd_addr = IdxBits'(i_q + CntBits'(1));
          state_d = S_FREE_SCAN;
        end
      end
      S_FREE_HI: begin
        // merge results: new base entry and removal count
        if (!found_q) begin
          // rd_q: lower neighbour
          found_d = 1'b1;
          if (pick_q != '0 && free_q[IdxBits'(pick_q - IdxBits'(1))]) begin
            pstart_d = e_start;
            psize_d  = psize_q + e_size;
            pick_d   = IdxBits'(pick_q - IdxBits'(1));
            acc_d    = SizeBits'(1);
          end else begin
            acc_d    = '0;
          end
          rd_addr = IdxBits'(i_q + CntBits'(1));
        end else begin
          // rd_q: upper neighbour of the original entry
          if (i_q + CntBits'(1) < cnt_q && free_q[IdxBits'(i_q + CntBits'(1))]) begin
            psize_d = psize_q + e_size;
            acc_d   = acc_q + SizeBits'(1);
          end
          state_d = S_SHIFT_DN;
          i_d     = CntBits'(pick_q) + CntBits'(1);
        end
      end
      S_SHIFT_DN: begin
        // write merged base, then move entries down by acc
        if (acc_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = pick_q;
          wr_data = {pstart_q, psize_q, IdBits'(0)};
          if (pick_q == '0) init_d = 1'b0;
          free_d[pick_q] = 1'b1;
          state_d = S_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pick_q;
          wr_data = {pstart_q, psize_q, IdBits'(0)};
          if (pick_q == '0) init_d = 1'b0;
          free_d[pick_q] = 1'b1;
          cnt_d   = cnt_q - CntBits'(acc_q);
          i_d     = CntBits'(pick_q) + CntBits'(1);
          rd_addr = IdxBits'(CntBits'(pick_q) + CntBits'(1) + CntBits'(acc_q));
          state_d = (CntBits'(pick_q) + CntBits'(1) < cnt_q - CntBits'(acc_q))
                    ? S_SCAN_DN_W : S_DONE;
        end
      end
      S_SCAN_DN_W: begin
        // rd_q holds entry i+acc
        wr_en   = 1'b1;
        wr_addr = i_idx;
        wr_data = {r_start, r_size, r_owner};
        free_d[i_idx] = free_q[IdxBits'(i_q + CntBits'(acc_q))];
        i_d     = i_q + CntBits'(1);
        rd_addr = IdxBits'(i_q + CntBits'(1) + CntBits'(acc_q));
        if (i_q + CntBits'(1) >= cnt_q) state_d = S_DONE;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

// ===== verif/variable_block_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_block_allocator_unit_test
// drives allocate, free, reinit and no-op beats into the segment allocator
// under every fit policy and several memory sizes; a table-walking predictor
// computes the expected status and id of each beat that has no fixed expectation,
// and results are compared in order as they are strobed out
// ----------------------------------------------------------------------------
module variable_block_allocator_unit_test;
  import vba_pkg::*;

  localparam int Limit = 5000;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t rsp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [20:0] cfg_data_i = '0;
  logic        done_o;
  rsp_t        rsp_o;

  variable_block_allocator_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .rsp_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // segment table mirror
  logic [AddrBits-1:0] seg_base[MaxSegments];
  logic [SizeBits-1:0] seg_len[MaxSegments];
  bit                  seg_open[MaxSegments];
  logic [IdBits-1:0]   seg_id[MaxSegments];
  int                  seg_cnt;
  logic [IdBits-1:0]   next_id;
  policy_e             policy;
  logic [20:0]         mem_bytes;
  int                  live_ids[$];
  rsp_t                pending_rsp[$];
  int                  errors = 0;
  int                  idle_cycles = 0;

  function automatic void rebuild_segments();
    seg_base[0] = '0;
    seg_len[0]  = (mem_bytes > 21'(1 << AddrBits)) ? 21'(1 << AddrBits) : mem_bytes;
    seg_open[0] = 1'b1;
    seg_id[0]   = '0;
    seg_cnt     = 1;
    next_id     = 1;
    live_ids.delete();
  endfunction

  function automatic void drop_segment(int k);
    for (int j = k; j + 1 < seg_cnt; j++) begin
      seg_base[j] = seg_base[j+1];
      seg_len[j]  = seg_len[j+1];
      seg_open[j] = seg_open[j+1];
      seg_id[j]   = seg_id[j+1];
    end
    seg_cnt--;
  endfunction

  function automatic rsp_t allocate_segment(logic [20:0] want);
    rsp_t o;
    int   pick;
    bit   found;
    o = '0;
    pick = 0;
    found = 1'b0;
    if (want == 0 || next_id == 0) begin
      o.status = ST_NO_FIT;
      return o;
    end
    for (int k = 0; k < seg_cnt; k++) begin
      if (!seg_open[k] || seg_len[k] < want) continue;
      if (!found) begin
        pick = k;
        found = 1'b1;
        if (policy != POL_BEST && policy != POL_WORST) break;
      end else if (policy == POL_BEST && seg_len[k] < seg_len[pick]) begin
        pick = k;
      end else if (policy == POL_WORST && seg_len[k] > seg_len[pick]) begin
        pick = k;
      end
    end
    if (!found) begin
      o.status = ST_NO_FIT;
      return o;
    end
    if (seg_len[pick] > want) begin
      if (seg_cnt >= MaxSegments) begin
        o.status = ST_FULL;
        return o;
      end
      for (int j = seg_cnt; j > pick + 1; j--) begin
        seg_base[j] = seg_base[j-1];
        seg_len[j]  = seg_len[j-1];
        seg_open[j] = seg_open[j-1];
        seg_id[j]   = seg_id[j-1];
      end
      seg_base[pick+1] = seg_base[pick] + want[AddrBits-1:0];
      seg_len[pick+1]  = seg_len[pick] - want;
      seg_open[pick+1] = 1'b1;
      seg_id[pick+1]   = '0;
      seg_cnt++;
      seg_len[pick] = want;
    end
    seg_open[pick] = 1'b0;
    seg_id[pick]   = next_id;
    o.alloc_id     = next_id;
    live_ids.push_back(int'(next_id));
    next_id++;
    return o;
  endfunction

  function automatic logic [1:0] release_segment(logic [15:0] id);
    int i;
    i = 0;
    while (i < seg_cnt && !(!seg_open[i] && seg_id[i] == id)) i++;
    if (i >= seg_cnt) return ST_NO_ID;
    foreach (live_ids[k]) begin
      if (live_ids[k] == int'(id)) begin
        live_ids.delete(k);
        break;
      end
    end
    seg_open[i] = 1'b1;
    seg_id[i]   = '0;
    if (i > 0 && seg_open[i-1]) begin
      seg_len[i-1] += seg_len[i];
      drop_segment(i);
      i--;
    end
    if (i + 1 < seg_cnt && seg_open[i+1]) begin
      seg_len[i] += seg_len[i+1];
      drop_segment(i + 1);
    end
    return ST_OK;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    o = '0;
    case (action_e'(r.action))
      ACT_ALLOC:  o = allocate_segment(r.request_size);
      ACT_FREE:   o.status = release_segment(r.release_id);
      ACT_REINIT: rebuild_segments();
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_beat(req_t r, int gap, bit typed = 1'b0, rsp_t typed_rsp = '0);
    rsp_t o;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    o = predict_rsp(r);
    pending_rsp.push_back(typed ? typed_rsp : o);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [20:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPolicy) policy = policy_e'(data[1:0]);
    else mem_bytes = data;
  endtask

  function automatic req_t mk(action_e a, logic [20:0] sz, logic [15:0] id);
    req_t r;
    r.action = a;
    r.request_size = sz;
    r.release_id = id;
    return r;
  endfunction

  function automatic rsp_t rs(status_e s, logic [15:0] id);
    rsp_t o;
    o.status = s;
    o.alloc_id = id;
    return o;
  endfunction

  task automatic setup(policy_e p, logic [20:0] bytes);
    write_reg(CfgPolicy, 21'(p));
    write_reg(CfgMemSize, bytes);
    send_beat(mk(ACT_REINIT, '0, '0), 0, 1'b1, rs(ST_OK, 0));
  endtask

  task automatic random_phase(int n);
    req_t r;
    int   roll;
    bit   calm;
    int   gap;
    calm = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      r = mk(ACT_ALLOC, '0, 16'($urandom));
      r.request_size = 21'($urandom);
      if (roll < 48) begin
        if ($urandom_range(0, 9) != 0)
          r.request_size = 21'($urandom_range(1, int'(mem_bytes) / 8 + 2));
      end else if (roll < 88) begin
        r.action = ACT_FREE;
        if (live_ids.size() != 0 && $urandom_range(0, 9) != 0)
          r.release_id = 16'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
      end else if (roll < 93) begin
        r.action = ACT_REINIT;
      end else begin
        r.action = ACT_NOP;
      end
      gap = calm ? 0 : $urandom_range(0, 8);
      send_beat(r, gap);
    end
  endtask

  row_t plan[$];

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result beat: status %0d alloc_id %0d", rsp_o.status, rsp_o.alloc_id);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.alloc_id !== want.alloc_id) begin
          $error("alloc_id: expected %0d, got %0d", want.alloc_id, rsp_o.alloc_id);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= Limit) begin
      $display("variable_block_allocator_unit_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    policy = POL_FIRST;
    mem_bytes = 21'd1024;
    rebuild_segments();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      '{mk(ACT_ALLOC, 21'd0, 16'hffff), 1'b1, rs(ST_NO_FIT, 0)},
      '{mk(ACT_ALLOC, 21'h1fffff, 16'd0), 1'b1, rs(ST_NO_FIT, 0)},
      '{mk(ACT_ALLOC, 21'd1024, 16'd0), 1'b1, rs(ST_OK, 1)},
      '{mk(ACT_ALLOC, 21'd1, 16'd0), 1'b1, rs(ST_NO_FIT, 0)},
      '{mk(ACT_FREE, 21'h1fffff, 16'd0), 1'b1, rs(ST_NO_ID, 0)},
      '{mk(ACT_FREE, 21'd0, 16'hffff), 1'b1, rs(ST_NO_ID, 0)},
      '{mk(ACT_FREE, 21'd0, 16'd1), 1'b1, rs(ST_OK, 0)},
      '{mk(ACT_NOP, 21'h1fffff, 16'hffff), 1'b1, rs(ST_OK, 0)},
      '{mk(ACT_ALLOC, 21'd100, 16'd0), 1'b1, rs(ST_OK, 2)},
      '{mk(ACT_ALLOC, 21'd200, 16'd0), 1'b0, '0},
      '{mk(ACT_ALLOC, 21'd300, 16'd0), 1'b0, '0},
      '{mk(ACT_FREE, 21'd0, 16'd3), 1'b0, '0},
      '{mk(ACT_FREE, 21'd0, 16'd2), 1'b0, '0},
      '{mk(ACT_ALLOC, 21'd50, 16'd0), 1'b0, '0},
      '{mk(ACT_FREE, 21'd0, 16'd4), 1'b0, '0},
      '{mk(ACT_FREE, 21'd0, 16'd5), 1'b0, '0},
      '{mk(ACT_REINIT, 21'd0, 16'd0), 1'b1, rs(ST_OK, 0)},
      '{mk(ACT_ALLOC, 21'd1, 16'd0), 1'b1, rs(ST_OK, 1)}
    };
    foreach (plan[i]) send_beat(plan[i].r, $urandom_range(0, 8), plan[i].typed, plan[i].rsp);

    // zero memory, nothing fits
    setup(POL_FIRST, 21'd0);
    send_beat(mk(ACT_ALLOC, 21'd1, 16'd0), 0, 1'b1, rs(ST_NO_FIT, 0));

    // fill the table, then split refused but exact fit accepted
    setup(POL_RSVD, 21'd1024);
    for (int i = 0; i < MaxSegments - 1; i++) send_beat(mk(ACT_ALLOC, 21'd1, '0), 0);
    send_beat(mk(ACT_ALLOC, 21'd1, 16'd0), 0, 1'b1, rs(ST_FULL, 0));
    send_beat(mk(ACT_ALLOC, 21'd961, 16'd0), 0, 1'b1, rs(ST_OK, 64));

    setup(POL_BEST, 21'd4096);
    random_phase(330);
    setup(POL_WORST, 21'h100000);
    random_phase(330);
    setup(POL_RSVD, 21'd300);
    random_phase(330);
    setup(POL_FIRST, 21'h1fffff);
    random_phase(330);

    drain();
    if (errors == 0) begin
      $display("variable_block_allocator_unit_test: done, clean");
    end else begin
      $display("variable_block_allocator_unit_test: done, errors");
    end
    $finish;
  end

endmodule
